// ===== hw/rtl/cpf_pkg.sv =====
package cpf_pkg;

  // default and field widths
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FW_W   = 11;
  localparam int FH_W   = 12;
  localparam int POS_W  = 23;
  localparam int Q_W    = 24;
  localparam int DIV_W  = 23;
  localparam int SUM_W  = 20;
  localparam int PIX_W  = 32;
  localparam int ADDR_W = 5;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_COEF_TOP = 3'd0;
  localparam logic [2:0] REG_COEF_MID = 3'd1;
  localparam logic [2:0] REG_COEF_BOT = 3'd2;
  localparam logic [2:0] REG_FACTOR   = 3'd3;
  localparam logic [2:0] REG_OFFSET   = 3'd4;
  localparam logic [2:0] REG_WIDTH    = 3'd5;
  localparam logic [2:0] REG_HEIGHT   = 3'd6;

  // reset values
  localparam logic [23:0]     COEF_RST   = 24'h010101;
  localparam logic [15:0]     FACTOR_RST = 16'd9;
  localparam logic [8:0]      OFFSET_RST = 9'd0;
  localparam logic [FW_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] HEIGHT_RST = 12'd1024;

  typedef struct packed {
    logic [71:0]     coefs;   // bottom row, mid row, top row (top-left lowest)
    logic [15:0]     factor;
    logic [8:0]      offset;
    logic [FW_W-1:0] width;
    logic [FH_W-1:0] height;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input beat accepted
    logic advance;    // shift window, update line stores and input position
    logic pos_div;    // start position / width division
    logic xy_latch;   // capture column and row of the output position
    logic addr_x;     // read line stores at output column
    logic pick;       // take flushed pixel from line stores
    logic mac_clr;    // load centre pixel, clear accumulators
    logic mac_en;     // one multiply-accumulate step
    logic sum_div;    // start division of the current byte sum
    logic byte_done;  // finish current byte
    logic out_load;   // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drain;
    logic complete;
    logic near;       // output not due yet
    logic div_busy;
    logic interior;
    logic mac_last;
    logic byte_last;
    logic out_full;
  } status_t;

endpackage

// ===== hw/rtl/cpf_ram.sv =====
module cpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cpf_div.sv =====
module cpf_div #(
  parameter int N = cpf_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [N-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quo,
  output logic [N-1:0] rem
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [N:0]    trial;

  // restoring divider, one quotient bit per cycle
  assign trial = {rem, quo[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(N);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= N'(trial - {1'b0, dvs});
        quo <= {quo[N-2:0], 1'b1};
      end else begin
        rem <= trial[N-1:0];
        quo <= {quo[N-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/cpf_datapath.sv =====
module cpf_datapath #(
  parameter int MAX_WIDTH = cpf_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cpf_pkg::cfg_t            cfg,
  input  cpf_pkg::cmd_t            cmd,
  output cpf_pkg::status_t         st,
  input  logic [cpf_pkg::PIX_W-1:0] s_tdata,
  input  logic                     s_tuser,
  input  logic                     m_tready,
  output logic                     m_tvalid,
  output logic [cpf_pkg::PIX_W-1:0] m_tdata,
  output logic                     m_tlast
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int FW_W  = cpf_pkg::FW_W;
  localparam int FH_W  = cpf_pkg::FH_W;
  localparam int POS_W = cpf_pkg::POS_W;
  localparam int Q_W   = cpf_pkg::Q_W;
  localparam int DIV_W = cpf_pkg::DIV_W;
  localparam int SUM_W = cpf_pkg::SUM_W;
  localparam int PIX_W = cpf_pkg::PIX_W;

  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [AW-1:0]    col;
  logic [FH_W-1:0]  row;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] total;
  logic [Q_W-1:0]   q;
  logic [PIX_W-1:0] px;
  logic             drain;
  logic             complete;
  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] prev_rd;
  logic [PIX_W-1:0] older_rd;
  logic [AW-1:0]    raddr;
  logic [POS_W-1:0] x;
  logic [POS_W-1:0] y;
  logic [PIX_W-1:0] pix_res;
  logic [3:0]       k;
  logic [1:0]       b;
  logic signed [SUM_W-1:0] acc [3];
  logic signed [16:0] prod [3];
  logic signed [7:0]  coef;
  logic             neg;
  logic [16:0]      fmag;
  logic signed [SUM_W-1:0] sum_sel;
  logic [DIV_W-1:0] sum_mag;
  logic [DIV_W-1:0] div_a;
  logic [DIV_W-1:0] div_d;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic             div_busy;
  logic signed [20:0] qv;
  logic signed [20:0] v;
  logic [7:0]       vbyte;
  logic             fe;

  // effective geometry
  always_comb begin
    if (cfg.width == '0) begin
      w_eff = FW_W'(1);
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.width;
    end
    h_eff = (cfg.height == '0) ? FH_W'(1) : cfg.height;
  end

  // line stores
  assign raddr = cmd.addr_x ? x[AW-1:0] : col;

  cpf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk   (clk),
    .we    (cmd.advance),
    .waddr (col),
    .wdata (px),
    .raddr (raddr),
    .rdata (prev_rd)
  );

  cpf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (cmd.advance),
    .waddr (col),
    .wdata (prev_rd),
    .raddr (raddr),
    .rdata (older_rd)
  );

  // input beat capture, plus input index and frame size products
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px       <= s_tdata;
      drain    <= s_tuser;
      complete <= (row >= h_eff);
      q        <= Q_W'(row) * Q_W'(w_eff) + Q_W'(col);
      total    <= POS_W'(w_eff) * POS_W'(h_eff);
    end
  end

  // window and counters
  assign fe = (Q_W'(pos) + Q_W'(1)) >= Q_W'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pos <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cmd.advance) begin
        for (int r = 0; r < 3; r++) begin
          win[3*r]   <= win[3*r+1];
          win[3*r+1] <= win[3*r+2];
        end
        win[2] <= (row >= FH_W'(2)) ? older_rd : '0;
        win[5] <= (row >= FH_W'(1)) ? prev_rd : '0;
        win[8] <= px;
        if ((32'(col) + 1) >= 32'(w_eff)) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (cmd.out_load) begin
        if (fe) begin
          col <= '0;
          row <= '0;
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  // shared divider: output position by width, then byte sums by factor
  assign fmag    = cfg.factor[15] ? 17'(~{1'b1, cfg.factor} + 17'd1) : {1'b0, cfg.factor};
  assign sum_sel = acc[b];
  assign sum_mag = sum_sel[SUM_W-1] ? DIV_W'(-sum_sel) : DIV_W'(sum_sel);
  assign div_a   = cmd.pos_div ? pos : sum_mag;
  assign div_d   = cmd.pos_div ? DIV_W'(w_eff) : DIV_W'(fmag);

  cpf_div #(.N(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.pos_div | cmd.sum_div),
    .dividend (div_a),
    .divisor  (div_d),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.xy_latch) begin
      x <= rem;
      y <= quo;
    end
    if (cmd.sum_div) begin
      neg <= sum_sel[SUM_W-1] ^ cfg.factor[15];
    end
  end

  // multiply-accumulate over the nine taps, three lanes
  assign coef = $signed(cfg.coefs[{k, 3'b000} +: 8]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      prod[l] = $signed({1'b0, win[k][8*l +: 8]}) * coef;
    end
  end

  // scale, offset and clamp one byte
  assign qv    = neg ? -$signed(21'(quo)) : $signed(21'(quo));
  assign v     = qv + $signed({{12{cfg.offset[8]}}, cfg.offset});
  assign vbyte = (v < 0) ? 8'd0 : ((v > 21'sd255) ? 8'd255 : v[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      b <= '0;
    end else begin
      if (cmd.mac_clr) begin
        k <= '0;
        b <= '0;
      end else if (cmd.mac_en) begin
        k <= k + 1'b1;
      end
      if (cmd.byte_done) begin
        b <= b + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_clr) begin
      pix_res <= win[4];
      for (int l = 0; l < 3; l++) begin
        acc[l] <= '0;
      end
    end else if (cmd.mac_en) begin
      for (int l = 0; l < 3; l++) begin
        acc[l] <= acc[l] + SUM_W'(prod[l]);
      end
    end else if (cmd.byte_done) begin
      pix_res[8*b +: 8] <= vbyte;
    end else if (cmd.pick) begin
      pix_res <= ((Q_W'(y) + Q_W'(1)) == Q_W'(row)) ? prev_rd : older_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= pix_res;
      m_tlast <= fe;
    end
  end

  // status
  assign st.drain     = drain;
  assign st.complete  = complete;
  assign st.near      = q < (Q_W'(pos) + Q_W'(w_eff) + Q_W'(1));
  assign st.div_busy  = div_busy;
  assign st.interior  = (cfg.factor != '0) && (x != '0) && (y != '0)
                        && ((Q_W'(x) + Q_W'(2)) <= Q_W'(w_eff))
                        && ((Q_W'(y) + Q_W'(2)) <= Q_W'(h_eff));
  assign st.mac_last  = (k == 4'd8);
  assign st.byte_last = (b == 2'd2);
  assign st.out_full  = m_tvalid;

endmodule

// ===== hw/rtl/cpf_ctrl.sv =====
module cpf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             m_tready,
  input  cpf_pkg::status_t st,
  output cpf_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_DIVP  = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_MAC   = 4'd7;
  localparam logic [3:0] S_SDIV  = 4'd8;
  localparam logic [3:0] S_SWAIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DEC;
        end
      end
      // line store data for the accepted beat is valid here
      S_DEC: begin
        if (st.complete) begin
          cmd.pos_div = 1'b1;
          state_next  = S_DIVP;
        end else if (st.drain) begin
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (st.near) begin
          state_next = S_IDLE;
        end else begin
          cmd.pos_div = 1'b1;
          state_next  = S_DIVP;
        end
      end
      S_DIVP: begin
        if (!st.div_busy) begin
          cmd.xy_latch = 1'b1;
          state_next   = st.complete ? S_ADDR : S_CHK;
        end
      end
      S_ADDR: begin
        cmd.addr_x = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.pick   = 1'b1;
        state_next = S_OUT;
      end
      S_CHK: begin
        cmd.mac_clr = 1'b1;
        state_next  = st.interior ? S_MAC : S_OUT;
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        if (st.mac_last) begin
          state_next = S_SDIV;
        end
      end
      S_SDIV: begin
        cmd.sum_div = 1'b1;
        state_next  = S_SWAIT;
      end
      S_SWAIT: begin
        if (!st.div_busy) begin
          cmd.byte_done = 1'b1;
          state_next    = st.byte_last ? S_OUT : S_SDIV;
        end
      end
      S_OUT: begin
        if (!st.out_full || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/conv3x3_pixel_filter_top.sv =====
// 3x3 convolution filter on a raster pixel stream.
// Input beats (s_*) carry one pixel each, or a drain beat (s_tuser high)
// sent after the frame to flush the outputs still pending. Output beats
// (m_*) carry the filtered pixel; m_tlast marks the last pixel of a frame.
// Interior pixels get the weighted 3x3 sum per colour byte, divided by the
// factor, offset and clamped; border pixels and alpha pass unchanged, as do
// all pixels while the factor is zero. Outputs lag inputs by one line plus
// one pixel of beats. One beat is processed at a time. A border or flushed
// pixel waits on a 23-step serial division of the output position by the
// width; an interior pixel adds the nine multiply-accumulate steps and three
// 23-step divisions of the byte sums through that same divider.
// The result sits in an output register, so the next beat is taken while it
// waits; a stalled receiver holds the block only when the next result is
// ready. Synchronous reset clears the counters, window and output valid and
// restores register defaults; the line stores are not cleared.
// Registers are to be written over the APB port only while the stream is
// idle; the user must keep to this, as the block does not enforce it.
module conv3x3_pixel_filter_top #(
  parameter int MAX_WIDTH = cpf_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // in_byte0, in_byte1, in_byte2, in_alpha
  input  logic                        s_tuser,   // is_drain
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // out_byte0, out_byte1, out_byte2, out_alpha
  output logic                        m_tlast,   // frame_end
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  cpf_pkg::cfg_t    cfg;
  cpf_pkg::cmd_t    cmd;
  cpf_pkg::status_t st;
  logic [2:0]       reg_idx;
  logic             wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel & penable & pwrite & pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coefs  <= {cpf_pkg::COEF_RST, cpf_pkg::COEF_RST, cpf_pkg::COEF_RST};
      cfg.factor <= cpf_pkg::FACTOR_RST;
      cfg.offset <= cpf_pkg::OFFSET_RST;
      cfg.width  <= cpf_pkg::WIDTH_RST;
      cfg.height <= cpf_pkg::HEIGHT_RST;
    end else if (wr) begin
      case (reg_idx)
        cpf_pkg::REG_COEF_TOP: cfg.coefs[23:0]  <= pwdata[23:0];
        cpf_pkg::REG_COEF_MID: cfg.coefs[47:24] <= pwdata[23:0];
        cpf_pkg::REG_COEF_BOT: cfg.coefs[71:48] <= pwdata[23:0];
        cpf_pkg::REG_FACTOR:   cfg.factor       <= pwdata[15:0];
        cpf_pkg::REG_OFFSET:   cfg.offset       <= pwdata[8:0];
        cpf_pkg::REG_WIDTH:    cfg.width        <= pwdata[cpf_pkg::FW_W-1:0];
        cpf_pkg::REG_HEIGHT:   cfg.height       <= pwdata[cpf_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      cpf_pkg::REG_COEF_TOP: prdata = {8'd0, cfg.coefs[23:0]};
      cpf_pkg::REG_COEF_MID: prdata = {8'd0, cfg.coefs[47:24]};
      cpf_pkg::REG_COEF_BOT: prdata = {8'd0, cfg.coefs[71:48]};
      cpf_pkg::REG_FACTOR:   prdata = {16'd0, cfg.factor};
      cpf_pkg::REG_OFFSET:   prdata = {23'd0, cfg.offset};
      cpf_pkg::REG_WIDTH:    prdata = {21'd0, cfg.width};
      cpf_pkg::REG_HEIGHT:   prdata = {20'd0, cfg.height};
      default:               prdata = '0;
    endcase
  end

  cpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cpf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // checks
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !st.div_busy)
    else $error("input ready while divider busy");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten before taken");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without load");

endmodule
